// File: rtl/scgc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scgc_pkg
// Shared types and constants for the serial CRC generate/check core.
// ----------------------------------------------------------------------------
package scgc_pkg;

  localparam int MaxWidth   = 16;
  localparam int WidthBits  = 5;
  localparam int IdxBits    = $clog2(MaxWidth);
  localparam int CfgIdxBits = 2;
  localparam int CfgDataBits = 16;
  localparam int QueueDepth = 2;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_MODE  = 2'd0,
    CFG_WIDTH = 2'd1,
    CFG_TAPS  = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    MODE_GENERATE = 1'b0,
    MODE_CHECK    = 1'b1
  } crc_mode_t;

  localparam logic [WidthBits-1:0]  ResetWidth = 5'd7;
  localparam logic [MaxWidth-1:0]   ResetTaps  = 16'd39;

  typedef struct packed {
    logic data_bit;
    logic last;
  } scgc_in_t;

  typedef struct packed {
    logic crc_bit;
    logic crc_ok;
    logic run_end;
  } scgc_out_t;

  typedef struct packed {
    crc_mode_t             mode;
    logic [WidthBits-1:0]  width;
    logic [MaxWidth-1:0]   taps;
  } scgc_cfg_t;

  typedef struct packed {
    crc_mode_t             mode;
    logic [WidthBits-1:0]  width;
    logic                  ok;
    logic [MaxWidth-1:0]   rem;
  } scgc_job_t;

endpackage

// File: rtl/scgc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scgc_front
// Accept packet bits, run the remainder update, post one job per packet.
// ----------------------------------------------------------------------------
module scgc_front (
  input  logic                clk,
  input  logic                rst,
  input  scgc_pkg::scgc_cfg_t cfg,
  input  logic                data_valid,
  output logic                data_stall,
  input  scgc_pkg::scgc_in_t  data,
  input  logic                q_full,
  output logic                q_push,
  output scgc_pkg::scgc_job_t q_job
);
  import scgc_pkg::*;

  logic [MaxWidth-1:0]  remainder;
  logic [MaxWidth-1:0]  remainder_next;
  logic [WidthBits-1:0] w_eff;
  logic [MaxWidth-1:0]  mask;
  logic [MaxWidth-1:0]  r_in;
  logic [MaxWidth-1:0]  r_new;
  logic [IdxBits-1:0]   top_idx;
  logic                 top;
  logic                 accept;

  always_comb begin
    w_eff = cfg.width;
    if (cfg.width == '0) begin
      w_eff = WidthBits'(1);
    end else if (cfg.width > WidthBits'(MaxWidth)) begin
      w_eff = WidthBits'(MaxWidth);
    end
    mask    = MaxWidth'((33'(1) << w_eff) - 33'(1));
    r_in    = remainder & mask;
    top_idx = IdxBits'(w_eff - WidthBits'(1));
    top     = r_in[top_idx];
    if (cfg.mode == MODE_GENERATE) begin
      r_new = (r_in << 1) & mask;
      if (top ^ data.data_bit) begin
        r_new = r_new ^ (cfg.taps & mask);
      end
    end else begin
      r_new = ((r_in << 1) | MaxWidth'(data.data_bit)) & mask;
      if (top) begin
        r_new = r_new ^ (cfg.taps & mask);
      end
    end
  end

  assign data_stall = q_full;
  assign accept     = data_valid & ~q_full;
  assign q_push     = accept & data.last;

  always_comb begin
    q_job.mode  = cfg.mode;
    q_job.width = w_eff;
    q_job.ok    = (r_new == '0);
    q_job.rem   = r_new;
  end

  always_comb begin
    remainder_next = remainder;
    if (accept) begin
      remainder_next = data.last ? '0 : r_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remainder <= '0;
    end else begin
      remainder <= remainder_next;
    end
  end

endmodule

// File: rtl/scgc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scgc_queue
// Short job queue between the front and back parts.
// ----------------------------------------------------------------------------
module scgc_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  scgc_pkg::scgc_job_t push_job,
  output logic                full,
  input  logic                pop,
  output logic                head_valid,
  output scgc_pkg::scgc_job_t head_job
);
  import scgc_pkg::*;

  localparam int PtrBits = $clog2(QueueDepth);

  scgc_job_t            entries [QueueDepth];
  logic [PtrBits-1:0]   wr_ptr;
  logic [PtrBits-1:0]   rd_ptr;
  logic [PtrBits:0]     count;
  logic                 do_push;
  logic                 do_pop;

  assign full       = (count == (PtrBits+1)'(QueueDepth));
  assign head_valid = (count != '0);
  assign head_job   = entries[rd_ptr];
  assign do_push    = push & ~full;
  assign do_pop     = pop & head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PtrBits'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PtrBits'(1);
      end
      count <= count + (PtrBits+1)'(do_push) - (PtrBits+1)'(do_pop);
    end
  end

endmodule

// File: rtl/scgc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scgc_back
// Drain jobs into result requests: CRC bits MSB first, or one check verdict.
// ----------------------------------------------------------------------------
module scgc_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                head_valid,
  input  scgc_pkg::scgc_job_t head_job,
  output logic                pop,
  output logic                result_valid,
  input  logic                result_stall,
  output scgc_pkg::scgc_out_t result
);
  import scgc_pkg::*;

  logic [IdxBits-1:0]   bit_cnt;
  logic [IdxBits-1:0]   bit_cnt_next;
  logic                 out_load;
  logic                 final_bit;
  logic [IdxBits-1:0]   sel;
  scgc_out_t            item;

  assign out_load = head_valid & (~result_valid | ~result_stall);

  always_comb begin
    sel       = IdxBits'(head_job.width - WidthBits'(1) - WidthBits'(bit_cnt));
    final_bit = (WidthBits'(bit_cnt) == head_job.width - WidthBits'(1));
    if (head_job.mode == MODE_GENERATE) begin
      item.crc_bit = head_job.rem[sel];
      item.crc_ok  = 1'b0;
      item.run_end = final_bit;
    end else begin
      item.crc_bit = 1'b0;
      item.crc_ok  = head_job.ok;
      item.run_end = 1'b1;
    end
  end

  assign pop = out_load & item.run_end;

  always_comb begin
    bit_cnt_next = bit_cnt;
    if (out_load) begin
      bit_cnt_next = item.run_end ? '0 : bit_cnt + IdxBits'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_cnt      <= '0;
      result_valid <= 1'b0;
    end else begin
      bit_cnt <= bit_cnt_next;
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (~result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result <= item;
    end
  end

endmodule

// File: rtl/serial_crc_generate_check_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_crc_generate_check_core
// Bit-serial CRC generator/checker with programmable polynomial and degree.
// Jobs queue on a packet's last bit. Throughput: one data bit per cycle
// unless the queue is full; the output side emits w results per packet in
// generate mode and one in check mode, one result per cycle unless stalled.
// Reset: remainder cleared, queue emptied, mode generate, width 7, taps 39.
// ----------------------------------------------------------------------------
module serial_crc_generate_check_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [scgc_pkg::CfgIdxBits-1:0]     cfg_index,
  input  logic [scgc_pkg::CfgDataBits-1:0]    cfg_data,
  input  logic                                data_valid,
  output logic                                data_stall,
  input  scgc_pkg::scgc_in_t                  data,
  output logic                                result_valid,
  input  logic                                result_stall,
  output scgc_pkg::scgc_out_t                 result
);
  import scgc_pkg::*;

  scgc_cfg_t cfg;
  logic      q_full;
  logic      q_push;
  scgc_job_t q_job;
  logic      q_pop;
  logic      head_valid;
  scgc_job_t head_job;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode  <= MODE_GENERATE;
      cfg.width <= ResetWidth;
      cfg.taps  <= ResetTaps;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODE:  cfg.mode  <= crc_mode_t'(cfg_data[0]);
        CFG_WIDTH: cfg.width <= cfg_data[WidthBits-1:0];
        CFG_TAPS:  cfg.taps  <= cfg_data[MaxWidth-1:0];
        default:   ;
      endcase
    end
  end

  scgc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .data_valid (data_valid),
    .data_stall (data_stall),
    .data       (data),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_job      (q_job)
  );

  scgc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_job   (q_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  scgc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head_job     (head_job),
    .pop          (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

// File: sim/serial_crc_generate_check_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_crc_generate_check_core_tb
// Self-checking bench for the serial CRC generate/check core. A behavioral
// long-division predictor tracks mode, degree, taps and the running
// remainder, and queues the CRC bits or the pass flag each packet must
// produce. Directed packets cover the reset setting, degree and tap extremes,
// degree clamping, taps above the degree, short check packets and settings
// changed in the middle of a packet. Random packets then run under several
// settings, with bursty requests and a stalling result side.
// ----------------------------------------------------------------------------
module serial_crc_generate_check_core_tb;
  import scgc_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int SettleCycles = 4;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  cfg_reg_t               cfg_index = CFG_MODE;
  logic [CfgDataBits-1:0] cfg_data = '0;
  logic                   data_valid = 1'b0;
  logic                   data_stall;
  scgc_in_t               data = '0;
  logic                   result_valid;
  logic                   result_stall = 1'b0;
  scgc_out_t              result;

  crc_mode_t     pred_mode;
  logic [4:0]    pred_width;
  logic [15:0]   pred_taps;
  logic [15:0]   pred_rem;
  scgc_out_t     pending_crc_results[$];
  scgc_out_t     want;

  int mismatch_count = 0;
  int cycle_count = 0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_span = 0;
  int stall_style = 0;

  serial_crc_generate_check_core uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .data_valid   (data_valid),
    .data_stall   (data_stall),
    .data         (data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("serial_crc_generate_check_core verification failed");
      $finish;
    end
  end

  // result-side stall pattern: pick a new style each time the span counter runs out
  always @(posedge clk) begin
    if (stall_span == 0) begin
      stall_style <= $urandom_range(0, 3);
      stall_span <= $urandom_range(32, 160);
    end else begin
      stall_span <= stall_span - 1;
    end
    case (stall_style)
      0: result_stall <= 1'b0;
      1: result_stall <= ($urandom_range(0, 3) == 0);
      2: result_stall <= ($urandom_range(0, 3) != 0);
      default: result_stall <= ~result_stall;
    endcase
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (pending_crc_results.size() == 0) begin
        report_mismatch("result with no request pending");
      end else begin
        want = pending_crc_results.pop_front();
        if (result.crc_bit !== want.crc_bit)
          report_mismatch($sformatf("crc_bit got %b want %b", result.crc_bit, want.crc_bit));
        if (result.crc_ok !== want.crc_ok)
          report_mismatch($sformatf("crc_ok got %b want %b", result.crc_ok, want.crc_ok));
        if (result.run_end !== want.run_end)
          report_mismatch($sformatf("run_end got %b want %b", result.run_end, want.run_end));
      end
    end
  end

  function automatic int unsigned eff_degree();
    int unsigned w;
    w = pred_width;
    if (w < 1) w = 1;
    if (w > MaxWidth) w = MaxWidth;
    return w;
  endfunction

  function automatic logic [15:0] degree_mask(input int unsigned w);
    return 16'((32'h1 << w) - 1);
  endfunction

  function automatic void crc_divide_step(input logic bit_in, input logic last_in);
    int unsigned w;
    logic [15:0] mask;
    logic [15:0] taps;
    logic [15:0] r;
    logic top;
    w = eff_degree();
    mask = degree_mask(w);
    taps = pred_taps & mask;
    r = pred_rem & mask;
    top = r[w-1];
    if (pred_mode == MODE_GENERATE) begin
      r = (r << 1) & mask;
      if (top ^ bit_in) r = r ^ taps;
    end else begin
      r = ((r << 1) | 16'(bit_in)) & mask;
      if (top) r = r ^ taps;
    end
    pred_rem = r;
    if (last_in) begin
      if (pred_mode == MODE_GENERATE) begin
        for (int k = 0; k < int'(w); k++)
          pending_crc_results.insert(pending_crc_results.size(),
                                     scgc_out_t'{crc_bit: r[int'(w) - 1 - k],
                                                 crc_ok: 1'b0,
                                                 run_end: (k == int'(w) - 1)});
      end else begin
        pending_crc_results.insert(pending_crc_results.size(),
                                   scgc_out_t'{crc_bit: 1'b0, crc_ok: (r == 16'h0),
                                               run_end: 1'b1});
      end
      pred_rem = 16'h0;
    end
  endfunction

  // CRC of a bit string under the current degree and taps
  function automatic logic [15:0] crc_of(input logic [63:0] bits, input int len);
    int unsigned w;
    logic [15:0] mask;
    logic [15:0] r;
    logic top;
    w = eff_degree();
    mask = degree_mask(w);
    r = 16'h0;
    for (int i = len - 1; i >= 0; i--) begin
      top = r[w-1];
      r = (r << 1) & mask;
      if (top ^ bits[i]) r = r ^ (pred_taps & mask);
    end
    return r;
  endfunction

  task automatic send_request(input logic bit_in, input logic last_in);
    if (gap_left > 0) begin
      data_valid <= 1'b0;
      repeat (gap_left) @(posedge clk);
      gap_left = 0;
    end
    data_valid <= 1'b1;
    data <= scgc_in_t'{data_bit: bit_in, last: last_in};
    @(posedge clk);
    while (data_stall) @(posedge clk);
    crc_divide_step(bit_in, last_in);
    if (burst_left > 1) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
      gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    end
  endtask

  task automatic send_packet(input logic [63:0] bits, input int len);
    for (int i = len - 1; i >= 0; i--) send_request(bits[i], i == 0);
  endtask

  task automatic wait_for_results();
    data_valid <= 1'b0;
    while (pending_crc_results.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_MODE:  pred_mode = crc_mode_t'(value[0]);
      CFG_WIDTH: pred_width = value[4:0];
      CFG_TAPS:  pred_taps = value;
      default: ;
    endcase
  endtask

  task automatic set_config(input crc_mode_t m, input logic [15:0] w, input logic [15:0] t);
    wait_for_results();
    write_reg(CFG_MODE, 16'(m));
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_TAPS, t);
  endtask

  task automatic test_reset_defaults();
    send_packet(64'b1, 1);
    send_packet(64'b10, 2);
  endtask

  task automatic test_generate_extremes();
    set_config(MODE_GENERATE, 16'd1, 16'h0001);
    send_packet(64'b11, 2);
    set_config(MODE_GENERATE, 16'd16, 16'hFFFF);
    send_packet(64'b110, 3);
    set_config(MODE_GENERATE, 16'd16, 16'h0000);
    send_packet(64'b1, 1);
  endtask

  task automatic test_width_clamp();
    set_config(MODE_GENERATE, 16'd0, 16'hA5A5);
    send_packet(64'b10, 2);
    set_config(MODE_GENERATE, 16'hFFFF, 16'h5A5A);
    send_packet(64'b01, 2);
  endtask

  task automatic test_taps_above_degree();
    set_config(MODE_GENERATE, 16'd4, 16'hFFF3);
    send_packet(64'b11, 2);
  endtask

  task automatic test_check_mode();
    logic [15:0] crc;
    set_config(MODE_CHECK, 16'd3, 16'h0003);
    crc = crc_of(64'b10, 2);
    send_packet({59'b0, 2'b10, crc[2:0]}, 5);
    // packets shorter than the degree
    set_config(MODE_CHECK, 16'd16, 16'h8005);
    send_packet(64'b00, 2);
    send_packet(64'b10, 2);
  endtask

  task automatic test_config_mid_packet();
    set_config(MODE_GENERATE, 16'd8, 16'h0007);
    send_request(1'b1, 1'b0);
    send_request(1'b0, 1'b0);
    set_config(MODE_CHECK, 16'd3, 16'h0003);
    send_request(1'b1, 1'b0);
    send_request(1'b1, 1'b1);
  endtask

  task automatic test_random_traffic();
    int sent;
    int len;
    int w;
    logic [63:0] bits;
    logic [15:0] crc;
    logic [15:0] wsel;
    for (int phase = 0; phase < 5; phase++) begin
      wsel = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 65535))
                                         : 16'($urandom_range(1, 16));
      set_config(crc_mode_t'($urandom_range(0, 1)), wsel, 16'($urandom_range(0, 65535)));
      sent = 0;
      while (sent < 18) begin
        len = $urandom_range(1, 20);
        bits = {$urandom, $urandom};
        if (pred_mode == MODE_CHECK && $urandom_range(0, 4) != 0) begin
          w = int'(eff_degree());
          crc = crc_of(bits, len);
          bits = (bits << w) | 64'(crc);
          len = len + w;
          if ($urandom_range(0, 3) == 0) bits[$urandom_range(0, len - 1)] ^= 1'b1;
        end
        send_packet(bits, len);
        sent += len;
        if ($urandom_range(0, 5) == 0) wait_for_results();
      end
    end
  endtask

  initial begin
    pred_mode = MODE_GENERATE;
    pred_width = ResetWidth;
    pred_taps = ResetTaps;
    pred_rem = 16'h0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_generate_extremes();
    test_width_clamp();
    test_taps_above_degree();
    test_check_mode();
    test_config_mid_packet();
    test_random_traffic();
    wait_for_results();
    if (mismatch_count == 0) begin
      $display("serial_crc_generate_check_core verification clean");
    end else begin
      $display("serial_crc_generate_check_core verification failed");
    end
    $finish;
  end

endmodule
